[rtl/rspe_pkg.sv]
// rspe_pkg: shared constants, types and gf(256) helpers for the reed-solomon parity encoder
// depends on nothing; used by rspe_front, rspe_back and reed_solomon_parity_encoder through scoped names
package rspe_pkg;

  localparam int NUM_PARITY = 26;
  localparam logic [8:0] FieldPoly = 9'h11D;
  localparam logic [7:0] Alpha = 8'h02;

  localparam int CntW = $clog2(NUM_PARITY);
  localparam int QueueDepth = 2;
  localparam int QPtrW = $clog2(QueueDepth);
  localparam int QCntW = $clog2(QueueDepth + 1);

  typedef logic [NUM_PARITY-1:0][7:0] gen_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
  } item_t;

  // shift-and-add multiply, reduced by the field polynomial
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [8:0] sh;
    acc = 8'h00;
    sh  = {1'b0, a};
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ sh[7:0];
      end
      sh = {sh[7:0], 1'b0};
      if (sh[8]) begin
        sh = sh ^ FieldPoly;
      end
    end
    return acc;
  endfunction

  // generator with roots alpha^0 .. alpha^(NUM_PARITY-1), highest term implicit
  function automatic gen_t build_gen();
    gen_t       g;
    logic [7:0] root;
    g    = '0;
    root = 8'h01;
    g[NUM_PARITY-1] = 8'h01;
    for (int i = 0; i < NUM_PARITY; i++) begin
      for (int j = 0; j < NUM_PARITY; j++) begin
        g[j] = gf_mul(g[j], root);
        if (j + 1 < NUM_PARITY) begin
          g[j] = g[j] ^ g[j+1];
        end
      end
      root = gf_mul(root, Alpha);
    end
    return g;
  endfunction

  localparam gen_t GenCoef = build_gen();

endpackage

[rtl/rspe_in_if.sv]
// rspe_in_if: data byte channel with valid/ready handshake
// depends on nothing
interface rspe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_end;

  modport source (output valid, output data_byte, output block_end, input ready);
  modport sink (input valid, input data_byte, input block_end, output ready);
endinterface

[rtl/rspe_out_if.sv]
// rspe_out_if: encoded byte channel with valid/ready handshake
// depends on nothing
interface rspe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_parity;
  logic       run_end;

  modport source (output valid, output out_byte, output is_parity, output run_end, input ready);
  modport sink (input valid, input out_byte, input is_parity, input run_end, output ready);
endinterface

[rtl/rspe_front.sv]
// rspe_front: accepts input beats into a short queue toward the encoder back end
// depends on rspe_pkg, rspe_in_if
module rspe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  rspe_in_if.sink             data_i,
  output logic                q_valid_o,
  output rspe_pkg::item_t     q_item_o,
  input  logic                q_pop_i
);

  rspe_pkg::item_t                   mem_q [rspe_pkg::QueueDepth];
  logic [rspe_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [rspe_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [rspe_pkg::QCntW-1:0]        cnt_q, cnt_d;
  logic                              push;
  logic                              pop;

  assign data_i.ready = (cnt_q != rspe_pkg::QCntW'(rspe_pkg::QueueDepth));
  assign push         = data_i.valid && data_i.ready;
  assign q_valid_o    = (cnt_q != '0);
  assign pop          = q_pop_i && q_valid_o;
  assign q_item_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == rspe_pkg::QPtrW'(rspe_pkg::QueueDepth - 1)) ? '0
                                                                        : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == rspe_pkg::QPtrW'(rspe_pkg::QueueDepth - 1)) ? '0
                                                                        : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{data_byte: data_i.data_byte, block_end: data_i.block_end};
    end
  end

endmodule

[rtl/rspe_back.sv]
// rspe_back: lfsr remainder update, data echo and parity drain into an output register
// depends on rspe_pkg, rspe_out_if
module rspe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  rspe_pkg::item_t     q_item_i,
  output logic                q_pop_o,
  rspe_out_if.source          code_o
);

  localparam int N = rspe_pkg::NUM_PARITY;

  logic [N-1:0][7:0]           rem_q, rem_d;
  logic [N-1:0][7:0]           rem_shift;
  logic [N-1:0][7:0]           rem_fold;
  logic [7:0]                  factor;
  logic                        drain_q, drain_d;
  logic [rspe_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        last_par;
  logic                        adv;
  logic                        take;
  logic                        ovalid_q, ovalid_d;
  logic [7:0]                  obyte_q, obyte_d;
  logic                        opar_q, opar_d;
  logic                        oend_q, oend_d;

  // output register frees when empty or taken this cycle
  assign adv      = !ovalid_q || code_o.ready;
  assign q_pop_o  = !drain_q && adv;
  assign take     = q_pop_o && q_valid_i;
  assign factor   = q_item_i.data_byte ^ rem_q[0];
  assign last_par = (cnt_q == rspe_pkg::CntW'(N - 1));

  always_comb begin
    for (int j = 0; j < N; j++) begin
      rem_shift[j] = (j < N - 1) ? rem_q[(j < N - 1) ? j + 1 : j] : 8'h00;
      rem_fold[j]  = rem_shift[j] ^ rspe_pkg::gf_mul(rspe_pkg::GenCoef[j], factor);
    end
  end

  always_comb begin
    rem_d    = rem_q;
    drain_d  = drain_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    opar_d   = opar_q;
    oend_d   = oend_q;
    if (adv) begin
      ovalid_d = 1'b0;
    end
    if (drain_q && adv) begin
      // shifting out all parity bytes leaves the remainder cleared
      rem_d    = rem_shift;
      ovalid_d = 1'b1;
      obyte_d  = rem_q[0];
      opar_d   = 1'b1;
      oend_d   = last_par;
      cnt_d    = last_par ? '0 : cnt_q + 1'b1;
      drain_d  = !last_par;
    end else if (take) begin
      rem_d    = rem_fold;
      ovalid_d = 1'b1;
      obyte_d  = q_item_i.data_byte;
      opar_d   = 1'b0;
      oend_d   = 1'b0;
      drain_d  = q_item_i.block_end;
      cnt_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q    <= '0;
      drain_q  <= 1'b0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      rem_q    <= rem_d;
      drain_q  <= drain_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    opar_q  <= opar_d;
    oend_q  <= oend_d;
  end

  assign code_o.valid     = ovalid_q;
  assign code_o.out_byte  = obyte_q;
  assign code_o.is_parity = opar_q;
  assign code_o.run_end   = oend_q;

endmodule

[rtl/reed_solomon_parity_encoder.sv]
// path: an accepted data beat passes through the queue into the output register as its echo
// throughput: while code_o.ready holds, one data beat per cycle, and a beat with block_end
//   adds NUM_PARITY parity beats, one per cycle, during which the back end holds the queue
//   and the input stalls once full
// reset: rst_ni asynchronous active low clears the queue, the remainder, the drain counter
//   and the output valid; no clearing pass is needed
module reed_solomon_parity_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  rspe_in_if.sink     data_i,
  rspe_out_if.source  code_o
);

  // queue head toward the back end
  logic            q_valid;
  rspe_pkg::item_t q_item;
  logic            q_pop;

  // front: takes input beats into a two-entry queue, ready while not full
  rspe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .data_i    (data_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // back: folds each byte into the lfsr remainder (constant gf multipliers as xor nets),
  // echoes it, and on block end drains the remainder lowest index first, flagging the last
  rspe_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .code_o    (code_o)
  );

endmodule

[sim/tb_top.sv]
// tb_top: self-checking bench for the reed-solomon parity encoder, gf(256) with poly 0x11d
// depends on rspe_pkg, rspe_in_if, rspe_out_if and reed_solomon_parity_encoder from rtl
module tb_top;

  localparam int NP = rspe_pkg::NUM_PARITY;

  // low byte of the field polynomial, folded back in when x^8 falls out
  localparam logic [7:0] FieldLow = 8'h1D;
  localparam logic [7:0] AlphaRoot = 8'h02;

  // long receiver hold-off, sized so the input queue fills and backs up
  localparam int HoldCycles = 300;
  // no beat on either side for this long means the block is stuck
  localparam int WatchdogLimit = 2000;
  // drain margin after the last expected beat
  localparam int TailCycles = 12;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       parity_flag;
    logic       end_flag;
  } code_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rspe_in_if  data_if ();
  rspe_out_if code_if ();

  reed_solomon_parity_encoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .data_i (data_if),
    .code_o (code_if)
  );

  always #5 clk_i = ~clk_i;

  // generator taps and running remainder of the encoder being mirrored
  logic [7:0] gen_taps [NP];
  logic [7:0] remainder [NP];

  rspe_pkg::item_t pending_q [$];
  code_beat_t      expected_code_q [$];

  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // long hold-off requests, handed from the stimulus thread to the ready process
  int hold_req_count = 0;
  int hold_ack_count = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // gf(256) product: walk the bits of b, doubling a each step
  function automatic logic [7:0] gf256_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] prod;
    logic [7:0] x;
    prod = 8'h00;
    x    = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        prod ^= x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? FieldLow : 8'h00);
    end
    return prod;
  endfunction

  // multiply in (x + alpha^i) for i = 0 .. NP-1, leading one kept implicit
  task automatic build_gen_taps();
    logic [7:0] root;
    root = 8'h01;
    for (int j = 0; j < NP; j++) begin
      gen_taps[j] = 8'h00;
    end
    gen_taps[NP-1] = 8'h01;
    for (int i = 0; i < NP; i++) begin
      for (int j = 0; j < NP; j++) begin
        gen_taps[j] = gf256_times(gen_taps[j], root);
        if (j + 1 < NP) begin
          gen_taps[j] ^= gen_taps[j+1];
        end
      end
      root = gf256_times(root, AlphaRoot);
    end
  endtask

  // one lfsr division step per data byte; on block end queue all parity bytes
  task automatic encode_beat(input logic [7:0] data_byte, input logic block_end);
    logic [7:0] feedback;
    feedback = data_byte ^ remainder[0];
    for (int j = 0; j < NP - 1; j++) begin
      remainder[j] = remainder[j+1];
    end
    remainder[NP-1] = 8'h00;
    for (int j = 0; j < NP; j++) begin
      remainder[j] ^= gf256_times(gen_taps[j], feedback);
    end
    // echo of the data byte, never a parity or end marker
    expected_code_q.push_back('{data_byte, 1'b0, 1'b0});
    if (block_end) begin
      // parity lowest index first, end marker on the last one only
      for (int j = 0; j < NP; j++) begin
        expected_code_q.push_back('{remainder[j], 1'b1, j == NP - 1});
      end
      for (int j = 0; j < NP; j++) begin
        remainder[j] = 8'h00;
      end
    end
  endtask

  task automatic push_beat(input logic [7:0] data_byte, input logic block_end);
    pending_q.push_back('{data_byte: data_byte, block_end: block_end});
  endtask

  // whole blocks of random bytes until at least target beats are queued;
  // mostly short blocks, now and then a single byte or a full 44-byte block
  task automatic queue_random_blocks(input int target);
    int queued;
    int len;
    queued = 0;
    while (queued < target) begin
      case ($urandom_range(9))
        0: begin
          len = 44;
        end
        1: begin
          len = 1;
        end
        default: begin
          len = $urandom_range(20, 2);
        end
      endcase
      for (int k = 0; k < len; k++) begin
        push_beat(8'($urandom_range(255)), k == len - 1);
      end
      queued += len;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got %02h want %02h", $time, what, got, want);
    error_count++;
  endtask

  // sender: holds a beat until taken, then picks the next one or idles;
  // prediction is made here, at the edge where the beat is accepted
  always @(posedge clk_i) begin : driver
    rspe_pkg::item_t next_item;
    if (rst_ni) begin
      if (data_if.valid && data_if.ready) begin
        encode_beat(data_if.data_byte, data_if.block_end);
      end
      if (!data_if.valid || data_if.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_q.pop_front();
          data_if.valid     <= 1'b1;
          data_if.data_byte <= next_item.data_byte;
          data_if.block_end <= next_item.block_end;
        end else begin
          data_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready: a pending long hold-off wins over the random stalls
  always @(posedge clk_i) begin : receiver
    if (rst_ni) begin
      if (hold_req_count != hold_ack_count) begin
        hold_ack_count = hold_req_count;
        hold_left      = HoldCycles;
        code_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        code_if.ready <= 1'b0;
      end else begin
        code_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // checker and watchdog
  always @(posedge clk_i) begin : monitor
    code_beat_t want;
    if (rst_ni) begin
      if (code_if.valid && code_if.ready) begin
        if (expected_code_q.size() == 0) begin
          report_mismatch("beat with nothing expected", code_if.out_byte, 8'h00);
        end else begin
          want = expected_code_q.pop_front();
          if (code_if.out_byte !== want.code_byte) begin
            report_mismatch("out_byte", code_if.out_byte, want.code_byte);
          end
          if (code_if.is_parity !== want.parity_flag) begin
            report_mismatch("is_parity", 8'(code_if.is_parity), 8'(want.parity_flag));
          end
          if (code_if.run_end !== want.end_flag) begin
            report_mismatch("run_end", 8'(code_if.run_end), 8'(want.end_flag));
          end
        end
      end
      if ((code_if.valid && code_if.ready) || (data_if.valid && data_if.ready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // stimulus: directed blocks, then four idling phases of random blocks;
  // the queue is touched on falling edges only, away from the driver
  initial begin : stimulus
    data_if.valid     = 1'b0;
    data_if.data_byte = 8'h00;
    data_if.block_end = 1'b0;
    code_if.ready     = 1'b0;
    rst_ni            = 1'b0;
    build_gen_taps();
    for (int j = 0; j < NP; j++) begin
      remainder[j] = 8'h00;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single-byte blocks at both extremes, back to back
    push_beat(8'h00, 1'b1);
    push_beat(8'hFF, 1'b1);
    // all-zero block gives all-zero parity
    push_beat(8'h00, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'h00, 1'b1);
    // all-ones block
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b1);
    // walking and alternating bit patterns
    push_beat(8'h01, 1'b0);
    push_beat(8'h80, 1'b0);
    push_beat(8'h55, 1'b0);
    push_beat(8'hAA, 1'b0);
    push_beat(8'h0F, 1'b0);
    push_beat(8'hF0, 1'b1);
    // a lone byte right after a long drain
    push_beat(8'h7E, 1'b1);

    // no idling; the receiver also takes one long hold-off so the block backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random_blocks(100);
    hold_req_count++;
    while (pending_q.size() != 0 || data_if.valid || expected_code_q.size() != 0) begin
      @(negedge clk_i);
    end

    // sender idles about half the time
    send_idle_pct  = 48;
    recv_stall_pct = 0;
    queue_random_blocks(100);
    while (pending_q.size() != 0 || data_if.valid || expected_code_q.size() != 0) begin
      @(negedge clk_i);
    end

    // receiver stalls about half the time
    send_idle_pct  = 0;
    recv_stall_pct = 48;
    queue_random_blocks(100);
    while (pending_q.size() != 0 || data_if.valid || expected_code_q.size() != 0) begin
      @(negedge clk_i);
    end

    // both sides idle
    send_idle_pct  = 36;
    recv_stall_pct = 36;
    queue_random_blocks(100);
    while (pending_q.size() != 0 || data_if.valid || expected_code_q.size() != 0) begin
      @(negedge clk_i);
    end

    // let any stray beat show up before the verdict
    repeat (TailCycles) @(negedge clk_i);
    if (error_count == 0 && expected_code_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
